// ===== src/imu_tilt_attitude_estimator_assert.svh =====
// assertion macros for the imu tilt estimator checker
// expects clk_i and rst_ni in the scope of each use
`ifndef IMU_TILT_ATTITUDE_ESTIMATOR_ASSERT_SVH
`define IMU_TILT_ATTITUDE_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define IMU_AT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imu tilt check failed");

// next-cycle implication
`define IMU_AT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imu tilt check failed");

`endif

// ===== src/imu_tilt_pkg.sv =====
// shared types, constants and the cordic angle table of the imu tilt estimator
// no dependencies
package imu_tilt_pkg;

  localparam int unsigned NumAxes     = 6;
  localparam int unsigned DataW       = 16;
  localparam int unsigned DiffW       = 17;
  localparam int unsigned CountW      = 16;
  localparam int unsigned SumW        = 32;
  localparam int unsigned PeriodW     = 24;
  localparam int unsigned WeightW     = 16;
  localparam int unsigned CalibCount  = 200;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned CntW        = 5;
  localparam int unsigned CorW        = 29;
  localparam int unsigned AngW        = 26;
  localparam int unsigned ProdW       = 43;
  localparam int unsigned AccW        = 44;
  localparam int unsigned YawW        = 48;
  localparam int unsigned OutYawW     = 27;
  localparam int          OneG        = 4096;
  localparam int          GainComp    = 26981;
  localparam int          AngLimit    = 23040;
  localparam int          Deg90       = 90 * 65536;

  localparam int unsigned AxX = 0;
  localparam int unsigned AxY = 1;
  localparam int unsigned AxZ = 2;
  localparam int unsigned GyZ = 5;

  localparam logic RegPeriod = 1'b0;
  localparam logic RegWeight = 1'b1;

  typedef enum logic [1:0] {
    ACT_CAL = 2'd0,
    ACT_UPD = 2'd1,
    ACT_CLR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MUL_NUM  = 2'd0,
    MUL_PREV = 2'd1,
    MUL_RAW  = 2'd2,
    MUL_YAW  = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            cal_acc;
    logic            div_init;
    logic            div_step;
    logic            offs_set;
    logic            cor_load;
    logic            cor_step;
    logic            sel;
    logic [CntW-1:0] idx;
    logic            mul_en;
    mul_sel_e        mul_sel;
    logic            acc_load;
    logic            smooth_wr;
    logic            yaw_wr;
  } cmd_t;

  typedef struct packed {
    logic cal_reach;
  } status_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [AngW-1:0] atan_lut(logic [CntW-1:0] i);
    logic signed [AngW-1:0] r;
    unique case (i)
      5'd0:    r = AngW'(2949120);
      5'd1:    r = AngW'(1740967);
      5'd2:    r = AngW'(919879);
      5'd3:    r = AngW'(466945);
      5'd4:    r = AngW'(234379);
      5'd5:    r = AngW'(117304);
      5'd6:    r = AngW'(58666);
      5'd7:    r = AngW'(29335);
      5'd8:    r = AngW'(14668);
      5'd9:    r = AngW'(7334);
      5'd10:   r = AngW'(3667);
      5'd11:   r = AngW'(1833);
      5'd12:   r = AngW'(917);
      5'd13:   r = AngW'(458);
      5'd14:   r = AngW'(229);
      5'd15:   r = AngW'(115);
      5'd16:   r = AngW'(57);
      5'd17:   r = AngW'(29);
      5'd18:   r = AngW'(14);
      5'd19:   r = AngW'(7);
      5'd20:   r = AngW'(4);
      5'd21:   r = AngW'(2);
      5'd22:   r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/imu_tilt_ctrl.sv =====
// sequencer of the imu tilt estimator: steps the datapath through each action
// depends on imu_tilt_pkg
module imu_tilt_ctrl
  import imu_tilt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  status_t    status_i,
  input  logic       out_free_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o,
  output logic       out_load_o,
  output logic       out_done_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_CAL   = 14'h0002,
    S_DINIT = 14'h0004,
    S_DIV   = 14'h0008,
    S_OFFS  = 14'h0010,
    S_LOAD  = 14'h0020,
    S_ITER  = 14'h0040,
    S_SM1   = 14'h0080,
    S_SM2   = 14'h0100,
    S_SM3   = 14'h0200,
    S_YAW1  = 14'h0400,
    S_YAW2  = 14'h0800,
    S_CLR   = 14'h1000,
    S_OUT   = 14'h2000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pass_q, pass_d;
  logic            done_q, done_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    done_d     = done_q;
    cmd_o      = '0;
    cmd_o.sel  = pass_q;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    out_done_o = done_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          pass_d        = 1'b0;
          done_d        = 1'b0;
          unique case (action_i)
            ACT_CAL: state_d = S_CAL;
            ACT_UPD: state_d = S_LOAD;
            ACT_CLR: state_d = S_CLR;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_CAL: begin
        cmd_o.cal_acc = 1'b1;
        state_d = status_i.cal_reach ? S_DINIT : S_OUT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = S_OFFS;
        end
      end
      S_OFFS: begin
        cmd_o.offs_set = 1'b1;
        done_d  = 1'b1;
        state_d = S_OUT;
      end
      S_LOAD: begin
        cmd_o.cor_load = 1'b1;
        cnt_d   = '0;
        state_d = S_ITER;
      end
      S_ITER: begin
        cmd_o.cor_step = 1'b1;
        // pitch numerator is formed while the roll pass runs
        if (!pass_q) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_NUM;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          pass_d  = ~pass_q;
          state_d = pass_q ? S_SM1 : S_LOAD;
        end
      end
      S_SM1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PREV;
        state_d = S_SM2;
      end
      S_SM2: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_RAW;
        state_d = S_SM3;
      end
      S_SM3: begin
        cmd_o.smooth_wr = 1'b1;
        pass_d  = ~pass_q;
        state_d = pass_q ? S_YAW1 : S_SM1;
      end
      S_YAW1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_YAW;
        state_d = S_YAW2;
      end
      S_YAW2: begin
        cmd_o.yaw_wr = 1'b1;
        state_d = S_OUT;
      end
      S_CLR: begin
        cmd_o.clear = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== src/imu_tilt_dp.sv =====
// datapath of the imu tilt estimator: sums, divider lanes, cordic unit,
// shared multiplier, smoothing and yaw accumulator; depends on imu_tilt_pkg
module imu_tilt_dp
  import imu_tilt_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  input  logic [NumAxes*DataW-1:0]    sample_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_index_i,
  input  logic [PeriodW-1:0]          cfg_data_i,
  output status_t                     status_o,
  output logic signed [DataW-1:0]     roll_o,
  output logic signed [DataW-1:0]     pitch_o,
  output logic [OutYawW-1:0]          yaw_o
);

  // architectural state
  logic signed [SumW-1:0]  sums_q [NumAxes];
  logic [CountW-1:0]       count_q;
  logic signed [DataW-1:0] offs_q [NumAxes];
  logic signed [DataW-1:0] prev_roll_q, prev_pitch_q;
  logic signed [YawW-1:0]  yaw_q;
  logic [PeriodW-1:0]      period_q;
  logic [WeightW-1:0]      weight_q;

  // working registers
  logic signed [DataW-1:0] v_q [NumAxes];
  logic [SumW-1:0]         num_q [NumAxes];
  logic [CountW-1:0]       rem_q [NumAxes];
  logic                    neg_q [NumAxes];
  logic signed [CorW-1:0]  cx_q, cy_q;
  logic signed [AngW-1:0]  cz_q;
  logic                    zero_q;
  logic signed [DataW-1:0] raw_roll_q;
  logic signed [ProdW-1:0] prod_q, acc_q;

  logic signed [DiffW-1:0]  diff     [NumAxes];
  logic signed [SumW:0]     sum_ext  [NumAxes];
  logic signed [SumW-1:0]   sum_sat  [NumAxes];
  logic [SumW-1:0]          mag      [NumAxes];
  logic [CountW:0]          dtry     [NumAxes];
  logic                     dge      [NumAxes];
  logic [CountW-1:0]        rem_nx   [NumAxes];
  logic signed [SumW+1:0]   avg      [NumAxes];
  logic signed [DataW-1:0]  offs_new [NumAxes];
  logic [CountW-1:0]        cnt_inc;
  logic signed [CorW-1:0]   ld_x, ld_y, pr_x, pr_y, sx, sy, nx, ny;
  logic signed [AngW-1:0]   pr_z, nz, atan_v, ang;
  logic                     pr_zero;
  logic signed [DataW-1:0]  raw_pitch, prev_sel, raw_sel, sm_val;
  logic signed [17:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [AccW-1:0]   sm_sum, sm_sh;
  logic signed [YawW:0]     y_sum;
  logic signed [YawW-1:0]   y_sat;

  function automatic logic signed [DataW-1:0] to_out(logic signed [AngW-1:0] z);
    logic signed [AngW:0] t;
    logic signed [DataW-1:0] r;
    t = ((AngW+1)'(z) + (AngW+1)'(256)) >>> 9;
    if (t > (AngW+1)'(AngLimit)) begin
      r = DataW'(AngLimit);
    end else if (t < (AngW+1)'(-AngLimit)) begin
      r = DataW'(-AngLimit);
    end else begin
      r = t[DataW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      diff[i]    = DiffW'(v_q[i]) - DiffW'(offs_q[i]);
      sum_ext[i] = (SumW+1)'(sums_q[i]) + (SumW+1)'(v_q[i]);
      if (sum_ext[i][SumW] != sum_ext[i][SumW-1]) begin
        sum_sat[i] = {sum_ext[i][SumW], {(SumW-1){~sum_ext[i][SumW]}}};
      end else begin
        sum_sat[i] = sum_ext[i][SumW-1:0];
      end
      mag[i]    = sums_q[i][SumW-1] ? SumW'(-sums_q[i]) : SumW'(sums_q[i]);
      // one restoring divide step per cycle in each lane
      dtry[i]   = {rem_q[i], num_q[i][SumW-1]};
      dge[i]    = dtry[i] >= {1'b0, count_q};
      rem_nx[i] = dge[i] ? CountW'(dtry[i] - {1'b0, count_q}) : dtry[i][CountW-1:0];
      avg[i]    = $signed({2'b00, num_q[i]});
      if (neg_q[i]) begin
        avg[i] = -avg[i];
      end
      if (i == AxZ) begin
        avg[i] = avg[i] - (SumW+2)'(OneG);
      end
      if (avg[i] > (SumW+2)'(32767)) begin
        offs_new[i] = DataW'(32767);
      end else if (avg[i] < (SumW+2)'(-32768)) begin
        offs_new[i] = DataW'(-32768);
      end else begin
        offs_new[i] = avg[i][DataW-1:0];
      end
    end
    cnt_inc = (count_q == '1) ? count_q : count_q + 1'b1;
    status_o.cal_reach = cnt_inc >= CountW'(CalibCount);

    // cordic load with quadrant pre-rotation
    if (!cmd_i.sel) begin
      ld_x = CorW'(diff[AxZ]) <<< 8;
      ld_y = CorW'(diff[AxY]) <<< 8;
    end else begin
      ld_x = cx_q;
      ld_y = CorW'(prod_q >>> 6);
    end
    pr_zero = (ld_x == '0) && (ld_y == '0);
    pr_x = ld_x;
    pr_y = ld_y;
    pr_z = '0;
    if (ld_x < 0) begin
      if (ld_y >= 0) begin
        pr_x = ld_y;
        pr_y = -ld_x;
        pr_z = AngW'(Deg90);
      end else begin
        pr_x = -ld_y;
        pr_y = ld_x;
        pr_z = AngW'(-Deg90);
      end
    end

    sx     = cx_q >>> cmd_i.idx;
    sy     = cy_q >>> cmd_i.idx;
    atan_v = atan_lut(cmd_i.idx);
    if (!cy_q[CorW-1]) begin
      nx = cx_q + sy;
      ny = cy_q - sx;
      nz = cz_q + atan_v;
    end else begin
      nx = cx_q - sy;
      ny = cy_q + sx;
      nz = cz_q - atan_v;
    end

    ang       = zero_q ? '0 : cz_q;
    raw_pitch = to_out(ang);

    prev_sel = cmd_i.sel ? prev_pitch_q : prev_roll_q;
    raw_sel  = cmd_i.sel ? raw_pitch : raw_roll_q;
    unique case (cmd_i.mul_sel)
      MUL_NUM: begin
        mul_a = -18'(diff[AxX]);
        mul_b = 25'(GainComp);
      end
      MUL_PREV: begin
        mul_a = 18'(prev_sel);
        mul_b = $signed({9'd0, weight_q});
      end
      MUL_RAW: begin
        mul_a = 18'(raw_sel);
        mul_b = $signed({8'd0, 17'h10000 - {1'b0, weight_q}});
      end
      MUL_YAW: begin
        mul_a = 18'(diff[GyZ]);
        mul_b = $signed({1'b0, period_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    sm_sum = AccW'(acc_q) + AccW'(prod_q) + AccW'(32768);
    sm_sh  = sm_sum >>> 16;
    if (sm_sh > AccW'(32767)) begin
      sm_val = DataW'(32767);
    end else if (sm_sh < AccW'(-32768)) begin
      sm_val = DataW'(-32768);
    end else begin
      sm_val = sm_sh[DataW-1:0];
    end

    y_sum = (YawW+1)'(yaw_q) + (YawW+1)'(prod_q);
    if (y_sum[YawW] != y_sum[YawW-1]) begin
      y_sat = {y_sum[YawW], {(YawW-1){~y_sum[YawW]}}};
    end else begin
      y_sat = y_sum[YawW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) begin
        sums_q[i] <= '0;
        offs_q[i] <= '0;
      end
      count_q      <= '0;
      prev_roll_q  <= '0;
      prev_pitch_q <= '0;
      yaw_q        <= '0;
      period_q     <= PeriodW'(16777);
      weight_q     <= WeightW'(45875);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegPeriod: period_q <= cfg_data_i;
          RegWeight: weight_q <= cfg_data_i[WeightW-1:0];
          default:   period_q <= period_q;
        endcase
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < NumAxes; i++) begin
          sums_q[i] <= '0;
          offs_q[i] <= '0;
        end
        count_q      <= '0;
        prev_roll_q  <= '0;
        prev_pitch_q <= '0;
        yaw_q        <= '0;
      end
      if (cmd_i.cal_acc) begin
        for (int i = 0; i < NumAxes; i++) begin
          sums_q[i] <= sum_sat[i];
        end
        count_q <= cnt_inc;
      end
      if (cmd_i.offs_set) begin
        for (int i = 0; i < NumAxes; i++) begin
          offs_q[i] <= offs_new[i];
        end
      end
      if (cmd_i.smooth_wr) begin
        if (cmd_i.sel) begin
          prev_pitch_q <= sm_val;
        end else begin
          prev_roll_q <= sm_val;
        end
      end
      if (cmd_i.yaw_wr) begin
        yaw_q <= y_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < NumAxes; i++) begin
        v_q[i] <= sample_i[i*DataW +: DataW];
      end
    end
    if (cmd_i.div_init) begin
      for (int i = 0; i < NumAxes; i++) begin
        num_q[i] <= mag[i] + SumW'(count_q[CountW-1:1]);
        rem_q[i] <= '0;
        neg_q[i] <= sums_q[i][SumW-1];
      end
    end
    if (cmd_i.div_step) begin
      for (int i = 0; i < NumAxes; i++) begin
        num_q[i] <= {num_q[i][SumW-2:0], dge[i]};
        rem_q[i] <= rem_nx[i];
      end
    end
    if (cmd_i.cor_load) begin
      cx_q   <= pr_x;
      cy_q   <= pr_y;
      cz_q   <= pr_z;
      zero_q <= pr_zero;
      if (cmd_i.sel) begin
        raw_roll_q <= to_out(ang);
      end
    end
    if (cmd_i.cor_step) begin
      cx_q <= nx;
      cy_q <= ny;
      cz_q <= nz;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end
  end

  assign roll_o  = prev_roll_q;
  assign pitch_o = prev_pitch_q;
  assign yaw_o   = yaw_q[YawW-1 -: OutYawW];

endmodule

// ===== src/imu_tilt_attitude_estimator.sv =====
// Tilt and heading estimator for six-axis IMU samples. One item is worked at a
// time: an attitude update runs two 16-step passes of the shared CORDIC unit
// (roll, then pitch) and the multiplier steps for smoothing and yaw; a
// calibrate item runs the 32-step offset divider once the sample count is
// reached. A finished result sits in the output register while the next
// item is taken. Configuration writes are taken in any cycle.
// depends on imu_tilt_pkg, imu_tilt_ctrl, imu_tilt_dp
module imu_tilt_attitude_estimator
  import imu_tilt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [NumAxes*DataW-1:0] s_axis_tdata_i,
  // action
  input  logic [1:0]               s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // roll_angle, pitch_angle, yaw_angle, zero fill
  output logic [63:0]              m_axis_tdata_o,
  // calib_done
  output logic [0:0]               m_axis_tuser_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [PeriodW-1:0]       cfg_data_i
);

  cmd_t                    cmd;
  status_t                 status;
  logic                    in_ready, out_load, out_done, out_free;
  logic signed [DataW-1:0] roll, pitch;
  logic [OutYawW-1:0]      yaw;
  logic                    m_valid_q;
  logic [63:0]             m_data_q;
  logic [0:0]              m_user_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  imu_tilt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .action_i   (s_axis_tuser_i),
    .status_i   (status),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .out_load_o (out_load),
    .out_done_o (out_done)
  );

  imu_tilt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .roll_o      (roll),
    .pitch_o     (pitch),
    .yaw_o       (yaw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {5'd0, yaw, pitch, roll};
      m_user_q <= out_done;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign cfg_ready_o     = 1'b1;

endmodule

// ===== src/imu_tilt_chk.sv =====
// port-level checks of the imu tilt estimator, bound to the top level
// depends on imu_tilt_attitude_estimator_assert.svh
`include "imu_tilt_attitude_estimator_assert.svh"

module imu_tilt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // stalled result holds
  `IMU_AT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // one item at a time: busy right after an accept
  `IMU_AT_NEXT(a_busy, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // a new result only comes out of a busy cycle
  `IMU_AT_IMPL(a_cause, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))
  // fill bits above the yaw field stay zero
  `IMU_AT_IMPL(a_pad, m_axis_tvalid_o, m_axis_tdata_o[63:59] == 5'd0)

endmodule

bind imu_tilt_attitude_estimator imu_tilt_chk u_chk (.*);
